FILE: rtl/core/ddp_pkg.sv
package ddp_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_MIN_DUTY        = 3'd0;
    localparam logic [2:0] CFG_MIN_TURN_DUTY   = 3'd1;
    localparam logic [2:0] CFG_MIN_SPEED_PCT   = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED_PCT   = 3'd3;
    localparam logic [2:0] CFG_TURN_STOP_PCT   = 3'd4;
    localparam logic [2:0] CFG_FRONT_STOP_DIST = 3'd5;
    localparam logic [2:0] CFG_BACK_STOP_DIST  = 3'd6;
    localparam logic [2:0] CFG_SIDE_DIFF_LIMIT = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_MIN_DUTY        = 8'd5;
    localparam logic [7:0]  RST_MIN_TURN_DUTY   = 8'd0;
    localparam logic [6:0]  RST_MIN_SPEED_PCT   = 7'd5;
    localparam logic [6:0]  RST_MAX_SPEED_PCT   = 7'd80;
    localparam logic [6:0]  RST_TURN_STOP_PCT   = 7'd20;
    localparam logic [15:0] RST_FRONT_STOP_DIST = 16'd400;
    localparam logic [15:0] RST_BACK_STOP_DIST  = 16'd400;
    localparam logic [15:0] RST_SIDE_DIFF_LIMIT = 16'd80;

    // drive pattern codes
    localparam logic [1:0] PAT_COAST   = 2'd0;
    localparam logic [1:0] PAT_FORWARD = 2'd1;
    localparam logic [1:0] PAT_REVERSE = 2'd2;

    // steer codes, two bit signed
    localparam logic [1:0] TURN_NONE  = 2'b00;
    localparam logic [1:0] TURN_RIGHT = 2'b01;
    localparam logic [1:0] TURN_LEFT  = 2'b11;

    // arithmetic constants
    localparam logic [7:0]  AUTO_PCT  = 8'd35;
    localparam logic [7:0]  FULL_DUTY = 8'd255;
    localparam logic [6:0]  FULL_PCT  = 7'd100;
    localparam logic [16:0] NO_ECHO_FAR = 17'h10000;
    // 13/20 as 13 * ceil(2^16 / 20), taken >> 16; exact for duties up to 255
    localparam logic [15:0] INNER_MUL = 16'd42601;

    // pipeline shape
    localparam int NSTG      = 8;
    localparam int NUM_W     = 15;
    localparam int DIV_W     = 7;
    localparam int DIV_STGS  = 3;
    localparam int DIV_STEPS = NUM_W / DIV_STGS;

    // control carried alongside the arithmetic
    typedef struct packed {
        logic       coast;
        logic [1:0] pattern;
        logic [1:0] turn;
        logic       use_min_turn;
    } ctl_t;

    // first stage: speed offset, span and divisor
    typedef struct packed {
        logic [DIV_W-1:0] mag;
        logic             neg;
        logic [7:0]       span;
        logic [DIV_W-1:0] dvs;
        logic             lo_full;
        ctl_t             ctl;
    } st1_t;

    // divider stages: partial remainder and shifting numerator/quotient
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] numq;
        logic             neg;
        logic [DIV_W-1:0] dvs;
        logic             lo_full;
        ctl_t             ctl;
    } dv_t;

    // a few restoring division steps
    function automatic dv_t div_stage(input dv_t x);
        dv_t          y;
        logic [DIV_W:0] trial;
        logic         ge;
        y = x;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial  = {y.rem, y.numq[NUM_W-1]};
            ge     = (trial >= {1'b0, y.dvs});
            y.numq = {y.numq[NUM_W-2:0], ge};
            if (ge) begin
                y.rem = DIV_W'(trial - {1'b0, y.dvs});
            end else begin
                y.rem = trial[DIV_W-1:0];
            end
        end
        return y;
    endfunction

endpackage

FILE: rtl/core/differential_drive_duty_planner_unit.sv
// throughput: one request per cycle while m_tready is high; an eight stage pipeline (decode, speed
// multiply, three radix-2 divider stages, base duty, inner multiply, output)
// reset: synchronous active-low aresetn empties the pipeline and loads the
// configuration registers with their default values; no clearing pass
module differential_drive_duty_planner_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // go, ahead, steer_request[1:0], speed_pct[7:0], front_dist[15:0],
    // back_dist[15:0], left_dist[15:0], right_dist[15:0], zero pad[3:0]
    input  logic [79:0] s_tdata,
    // auto_mode
    input  logic        s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_duty[7:0], right_duty[7:0], drive_pattern[1:0], turn_taken[1:0],
    // zero pad[3:0]
    output logic [23:0] m_tdata
);
    import ddp_pkg::*;

    // configuration registers
    logic [7:0]  min_duty_reg, min_turn_duty_reg;
    logic [6:0]  min_speed_pct_reg, max_speed_pct_reg, turn_stop_pct_reg;
    logic [15:0] front_stop_dist_reg, back_stop_dist_reg, side_diff_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_duty_reg        <= RST_MIN_DUTY;
            min_turn_duty_reg   <= RST_MIN_TURN_DUTY;
            min_speed_pct_reg   <= RST_MIN_SPEED_PCT;
            max_speed_pct_reg   <= RST_MAX_SPEED_PCT;
            turn_stop_pct_reg   <= RST_TURN_STOP_PCT;
            front_stop_dist_reg <= RST_FRONT_STOP_DIST;
            back_stop_dist_reg  <= RST_BACK_STOP_DIST;
            side_diff_limit_reg <= RST_SIDE_DIFF_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIN_DUTY:        min_duty_reg        <= cfg_data[7:0];
                CFG_MIN_TURN_DUTY:   min_turn_duty_reg   <= cfg_data[7:0];
                CFG_MIN_SPEED_PCT:   min_speed_pct_reg   <= cfg_data[6:0];
                CFG_MAX_SPEED_PCT:   max_speed_pct_reg   <= cfg_data[6:0];
                CFG_TURN_STOP_PCT:   turn_stop_pct_reg   <= cfg_data[6:0];
                CFG_FRONT_STOP_DIST: front_stop_dist_reg <= cfg_data;
                CFG_BACK_STOP_DIST:  back_stop_dist_reg  <= cfg_data;
                CFG_SIDE_DIFF_LIMIT: side_diff_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    logic        in_go, in_ahead;
    logic [1:0]  in_steer;
    logic [7:0]  in_pct;
    logic [15:0] in_front, in_back, in_left, in_right;

    assign in_go    = s_tdata[0];
    assign in_ahead = s_tdata[1];
    assign in_steer = s_tdata[3:2];
    assign in_pct   = s_tdata[11:4];
    assign in_front = s_tdata[27:12];
    assign in_back  = s_tdata[43:28];
    assign in_left  = s_tdata[59:44];
    assign in_right = s_tdata[75:60];

    // pipeline valids and per-stage advance
    logic [NSTG:1]   vld_reg;
    logic [NSTG+1:1] en;

    always_comb begin
        en[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = NSTG; k >= 2; k--) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en[1]) begin
                vld_reg[1] <= s_tvalid;
            end
        end
    end

    // stage 1 decode: obstacle checks, steer choice, speed clamp
    logic        front_blk, back_blk, has_l, has_r;
    logic [16:0] lc, rc;
    logic [15:0] side_mag;
    logic [7:0]  pct_eff, lo8, c_lo, c_hi;
    logic [8:0]  diff;
    logic [1:0]  auto_turn;
    st1_t        st1_next;

    always_comb begin
        front_blk = (in_front != 16'd0) && (in_front <= front_stop_dist_reg);
        back_blk  = (in_back != 16'd0) && (in_back <= back_stop_dist_reg);
        has_l     = (in_left != 16'd0);
        has_r     = (in_right != 16'd0);
        lc        = has_l ? {1'b0, in_left} : NO_ECHO_FAR;
        rc        = has_r ? {1'b0, in_right} : NO_ECHO_FAR;
        side_mag  = (in_left >= in_right) ? (in_left - in_right) : (in_right - in_left);

        // autonomous steer
        if (front_blk) begin
            auto_turn = (lc > rc) ? TURN_LEFT : TURN_RIGHT;
        end else if (has_l && has_r) begin
            if (side_mag > side_diff_limit_reg) begin
                auto_turn = (in_left > in_right) ? TURN_LEFT : TURN_RIGHT;
            end else begin
                auto_turn = TURN_NONE;
            end
        end else if (has_l) begin
            auto_turn = TURN_RIGHT;
        end else if (has_r) begin
            auto_turn = TURN_LEFT;
        end else begin
            auto_turn = TURN_NONE;
        end

        // speed clamp and offset from the map origin
        pct_eff = s_tuser ? AUTO_PCT : in_pct;
        lo8     = {1'b0, min_speed_pct_reg};
        c_lo    = (pct_eff < lo8) ? lo8 : pct_eff;
        c_hi    = (c_lo > {1'b0, max_speed_pct_reg}) ? {1'b0, max_speed_pct_reg} : c_lo;
        diff    = {1'b0, c_hi} - {1'b0, lo8};

        st1_next.neg     = diff[8];
        st1_next.mag     = diff[8] ? DIV_W'(-diff) : diff[DIV_W-1:0];
        st1_next.span    = FULL_DUTY - min_duty_reg;
        st1_next.dvs     = FULL_PCT - min_speed_pct_reg;
        st1_next.lo_full = (min_speed_pct_reg >= FULL_PCT);

        // mode and coast decision
        st1_next.ctl.use_min_turn = (pct_eff < {1'b0, turn_stop_pct_reg});
        if (s_tuser) begin
            st1_next.ctl.coast        = 1'b0;
            st1_next.ctl.pattern      = PAT_FORWARD;
            st1_next.ctl.turn         = auto_turn;
            st1_next.ctl.use_min_turn = st1_next.ctl.use_min_turn || front_blk;
        end else if (!in_go || (in_ahead && front_blk) || (!in_ahead && back_blk)) begin
            st1_next.ctl.coast   = 1'b1;
            st1_next.ctl.pattern = PAT_COAST;
            st1_next.ctl.turn    = TURN_NONE;
        end else begin
            st1_next.ctl.coast   = 1'b0;
            st1_next.ctl.pattern = in_ahead ? PAT_FORWARD : PAT_REVERSE;
            case (in_steer)
                TURN_LEFT:  st1_next.ctl.turn = TURN_LEFT;
                TURN_RIGHT: st1_next.ctl.turn = TURN_RIGHT;
                default:    st1_next.ctl.turn = TURN_NONE;
            endcase
        end
    end

    // stage 2: offset times duty span; stages 3 to 5: division by the span of percent
    st1_t st1_reg;
    dv_t  dv_reg [0:DIV_STGS];
    dv_t  dv0_next;

    always_comb begin
        dv0_next.rem     = '0;
        dv0_next.numq    = NUM_W'({8'd0, st1_reg.mag} * {7'd0, st1_reg.span});
        dv0_next.neg     = st1_reg.neg;
        dv0_next.dvs     = st1_reg.dvs;
        dv0_next.lo_full = st1_reg.lo_full;
        dv0_next.ctl     = st1_reg.ctl;
    end

    // stage 6: base duty from the quotient
    logic [7:0]  base_next;
    logic [15:0] base_sum;
    dv_t         dv_last;

    always_comb begin
        dv_last  = dv_reg[DIV_STGS];
        base_sum = {1'b0, dv_last.numq} + {8'd0, min_duty_reg};
        if (dv_last.lo_full) begin
            base_next = FULL_DUTY;
        end else if (dv_last.neg) begin
            base_next = min_duty_reg;
        end else if (base_sum > {8'd0, FULL_DUTY}) begin
            base_next = FULL_DUTY;
        end else begin
            base_next = base_sum[7:0];
        end
    end

    logic [7:0]  base6_reg, base7_reg, scaled7_reg;
    ctl_t        ctl6_reg, ctl7_reg;
    logic [23:0] scaled_prod;

    // stage 7: 13/20 of the base duty
    assign scaled_prod = {16'd0, base6_reg} * {8'd0, INNER_MUL};

    // stage 8: inner wheel and output word
    logic [7:0]  inner, left_duty, right_duty;
    logic [23:0] out_next, out_reg;

    always_comb begin
        if (ctl7_reg.use_min_turn || (scaled7_reg < min_turn_duty_reg)) begin
            inner = min_turn_duty_reg;
        end else begin
            inner = scaled7_reg;
        end
        left_duty  = (ctl7_reg.turn == TURN_LEFT) ? inner : base7_reg;
        right_duty = (ctl7_reg.turn == TURN_RIGHT) ? inner : base7_reg;
        if (ctl7_reg.coast) begin
            left_duty  = 8'd0;
            right_duty = 8'd0;
        end
        out_next = {4'd0, ctl7_reg.turn, ctl7_reg.pattern, right_duty, left_duty};
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            st1_reg <= st1_next;
        end
        if (en[2]) begin
            dv_reg[0] <= dv0_next;
        end
        for (int k = 1; k <= DIV_STGS; k++) begin
            if (en[k+2]) begin
                dv_reg[k] <= div_stage(dv_reg[k-1]);
            end
        end
        if (en[DIV_STGS+3]) begin
            base6_reg <= base_next;
            ctl6_reg  <= dv_last.ctl;
        end
        if (en[DIV_STGS+4]) begin
            base7_reg   <= base6_reg;
            scaled7_reg <= scaled_prod[23:16];
            ctl7_reg    <= ctl6_reg;
        end
        if (en[NSTG]) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

`ifndef SYNTHESIS
    // a coasting result carries no duty and no steer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[17:16] == PAT_COAST)) |->
        ((m_tdata[15:0] == 16'd0) && (m_tdata[19:18] == TURN_NONE)))
        else $error("coast result with nonzero duty or steer");

    // drive pattern and steer codes stay within their meaning
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[17:16] != 2'd3) && (m_tdata[19:18] != 2'b10)))
        else $error("illegal pattern or steer code");

    // an empty output stage never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NSTG] |-> s_tready)
        else $error("input stalled with empty output stage");

    // pipeline is empty straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

FILE: sim/ddp_duty_checker.sv
module ddp_duty_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          mismatches,
    output int          waiting,
    output int          compared
);
    import ddp_pkg::*;

    localparam int DUTY_TOP   = 255;
    localparam int PCT_TOP    = 100;
    localparam int AUTO_SPEED = 35;
    localparam int FAR_SIDE   = 65536;

    typedef struct packed {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic [1:0] pattern;
        logic [1:0] turn;
    } duty_set_t;

    // register copies, already masked to their width
    int cfg_min_duty;
    int cfg_min_turn_duty;
    int cfg_min_speed;
    int cfg_max_speed;
    int cfg_turn_stop;
    int cfg_front_stop;
    int cfg_back_stop;
    int cfg_side_diff;

    duty_set_t expected_duties [$];
    duty_set_t want;
    duty_set_t seen;

    // clamp the speed and map it onto the duty range
    function automatic int speed_to_duty(input int pct);
        int c;
        int lo;
        int d;
        c  = pct;
        lo = cfg_min_speed;
        if (c < lo) c = lo;
        if (c > cfg_max_speed) c = cfg_max_speed;
        if (lo >= PCT_TOP) begin
            d = DUTY_TOP;
        end else begin
            d = (c - lo) * (DUTY_TOP - cfg_min_duty) / (PCT_TOP - lo) + cfg_min_duty;
        end
        if (d < cfg_min_duty) d = cfg_min_duty;
        if (d > DUTY_TOP) d = DUTY_TOP;
        return d;
    endfunction

    // duty of the wheel on the inside of a turn
    function automatic int inner_wheel_duty(input int base, input int pct, input bit sharp);
        int d;
        if (sharp || pct < cfg_turn_stop) return cfg_min_turn_duty;
        d = base * 13 / 20;
        if (d < cfg_min_turn_duty) d = cfg_min_turn_duty;
        return d;
    endfunction

    // duties, pattern and steer for one control tick
    function automatic duty_set_t plan_duties(input logic [79:0] req, input logic auto_mode);
        logic      go;
        logic      ahead;
        logic [1:0] steer;
        int        pct;
        int        fd;
        int        bd;
        int        ld;
        int        rd;
        int        base;
        int        lc;
        int        rc;
        int        delta;
        int        mag;
        bit        front_blk;
        bit        back_blk;
        duty_set_t r;
        go        = req[0];
        ahead     = req[1];
        steer     = req[3:2];
        pct       = req[11:4];
        fd        = req[27:12];
        bd        = req[43:28];
        ld        = req[59:44];
        rd        = req[75:60];
        front_blk = (fd != 0) && (fd <= cfg_front_stop);
        back_blk  = (bd != 0) && (bd <= cfg_back_stop);
        r.left_duty  = '0;
        r.right_duty = '0;
        r.pattern    = PAT_COAST;
        r.turn       = TURN_NONE;
        if (auto_mode) begin
            base = speed_to_duty(AUTO_SPEED);
            r.left_duty  = 8'(base);
            r.right_duty = 8'(base);
            if (front_blk) begin
                // sharp turn toward the side with more room, a silent side is farthest
                lc = (ld != 0) ? ld : FAR_SIDE;
                rc = (rd != 0) ? rd : FAR_SIDE;
                r.turn = (lc > rc) ? TURN_LEFT : TURN_RIGHT;
            end else if (ld != 0 && rd != 0) begin
                delta = ld - rd;
                mag   = (delta < 0) ? -delta : delta;
                if (mag > cfg_side_diff) r.turn = (delta > 0) ? TURN_LEFT : TURN_RIGHT;
            end else if (ld != 0) begin
                r.turn = TURN_RIGHT;
            end else if (rd != 0) begin
                r.turn = TURN_LEFT;
            end
            if (r.turn == TURN_LEFT) begin
                r.left_duty = 8'(inner_wheel_duty(base, AUTO_SPEED, front_blk));
            end else if (r.turn == TURN_RIGHT) begin
                r.right_duty = 8'(inner_wheel_duty(base, AUTO_SPEED, front_blk));
            end
            r.pattern = PAT_FORWARD;
        end else if (!go || (ahead && front_blk) || (!ahead && back_blk)) begin
            // coasting keeps the cleared fields
            r.pattern = PAT_COAST;
        end else begin
            base = speed_to_duty(pct);
            r.left_duty  = 8'(base);
            r.right_duty = 8'(base);
            if (steer == TURN_LEFT) begin
                r.turn      = TURN_LEFT;
                r.left_duty = 8'(inner_wheel_duty(base, pct, 1'b0));
            end else if (steer == TURN_RIGHT) begin
                r.turn       = TURN_RIGHT;
                r.right_duty = 8'(inner_wheel_duty(base, pct, 1'b0));
            end
            r.pattern = ahead ? PAT_FORWARD : PAT_REVERSE;
        end
        return r;
    endfunction

    // watch the three channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_min_duty      = RST_MIN_DUTY;
            cfg_min_turn_duty = RST_MIN_TURN_DUTY;
            cfg_min_speed     = RST_MIN_SPEED_PCT;
            cfg_max_speed     = RST_MAX_SPEED_PCT;
            cfg_turn_stop     = RST_TURN_STOP_PCT;
            cfg_front_stop    = RST_FRONT_STOP_DIST;
            cfg_back_stop     = RST_BACK_STOP_DIST;
            cfg_side_diff     = RST_SIDE_DIFF_LIMIT;
            expected_duties.delete();
            mismatches = 0;
            compared   = 0;
            waiting    = 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_DUTY:        cfg_min_duty      = cfg_data[7:0];
                    CFG_MIN_TURN_DUTY:   cfg_min_turn_duty = cfg_data[7:0];
                    CFG_MIN_SPEED_PCT:   cfg_min_speed     = cfg_data[6:0];
                    CFG_MAX_SPEED_PCT:   cfg_max_speed     = cfg_data[6:0];
                    CFG_TURN_STOP_PCT:   cfg_turn_stop     = cfg_data[6:0];
                    CFG_FRONT_STOP_DIST: cfg_front_stop    = cfg_data;
                    CFG_BACK_STOP_DIST:  cfg_back_stop     = cfg_data;
                    CFG_SIDE_DIFF_LIMIT: cfg_side_diff     = cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (s_tvalid && s_tready) begin
                expected_duties.push_back(plan_duties(s_tdata, s_tuser));
            end
            // accepted result
            if (m_tvalid && m_tready) begin
                seen.left_duty  = m_tdata[7:0];
                seen.right_duty = m_tdata[15:8];
                seen.pattern    = m_tdata[17:16];
                seen.turn       = m_tdata[19:18];
                if (expected_duties.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: left %0d right %0d pattern %0d turn %b",
                                 seen.left_duty, seen.right_duty, seen.pattern, seen.turn);
                    end
                end else begin
                    want = expected_duties.pop_front();
                    compared++;
                    if (seen.left_duty !== want.left_duty || seen.right_duty !== want.right_duty ||
                        seen.pattern !== want.pattern || seen.turn !== want.turn) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected left %0d right %0d pattern %0d turn %b",
                                     compared, want.left_duty, want.right_duty, want.pattern,
                                     want.turn);
                            $display("result %0d: got      left %0d right %0d pattern %0d turn %b",
                                     compared, seen.left_duty, seen.right_duty, seen.pattern,
                                     seen.turn);
                        end
                    end
                end
            end
            waiting = expected_duties.size();
        end
    end

endmodule

FILE: sim/differential_drive_duty_planner_unit_test.sv
module differential_drive_duty_planner_unit_test;
    import ddp_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_REQUESTS = 116;
    localparam int NUM_SETTINGS   = 8;
    // steer code outside the three named turns, taken as straight
    localparam logic [1:0] TURN_ODD = 2'b10;

    typedef struct packed {
        logic        auto_mode;
        logic        go;
        logic        ahead;
        logic [1:0]  steer;
        logic [7:0]  speed_pct;
        logic [15:0] front_dist;
        logic [15:0] back_dist;
        logic [15:0] left_dist;
        logic [15:0] right_dist;
    } drive_request_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    int mismatches;
    int waiting;
    int compared;
    int tx_idle;
    int rx_idle;
    int requests_sent;
    int cycle_count;
    int cur_cfg [8];
    bit long_hold;
    bit hold_done;

    differential_drive_duty_planner_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ddp_duty_checker duty_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .waiting    (waiting),
        .compared   (compared)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[differential_drive_duty_planner_unit] ERROR");
            $finish;
        end
    end

    // result side: random back-pressure, or one long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle);
            end
        end
    end

    function automatic drive_request_t plan_request(
        input logic a, input logic g, input logic h, input logic [1:0] st,
        input logic [7:0] sp, input logic [15:0] f, input logic [15:0] b,
        input logic [15:0] l, input logic [15:0] r);
        drive_request_t rq;
        rq = '{a, g, h, st, sp, f, b, l, r};
        return rq;
    endfunction

    function automatic logic [15:0] register_mask(input logic [2:0] idx);
        case (idx)
            CFG_MIN_DUTY, CFG_MIN_TURN_DUTY: return 16'h00FF;
            CFG_MIN_SPEED_PCT, CFG_MAX_SPEED_PCT, CFG_TURN_STOP_PCT: return 16'h007F;
            default: return 16'hFFFF;
        endcase
    endfunction

    // distances cluster around the stop threshold
    function automatic logic [15:0] pick_distance(input int stop);
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'(stop);
            2: return 16'(stop + 1);
            3: return 16'(stop - 1);
            4: return 16'($urandom);
            5: return 16'(stop + $urandom_range(2, 400));
            6: return 16'($urandom_range(1, 8));
            default: return 16'($urandom_range(1, 1200));
        endcase
    endfunction

    // speeds cluster around the clamps and the inner-wheel threshold
    function automatic logic [7:0] pick_speed();
        case ($urandom_range(0, 6))
            0: return 8'($urandom);
            1: return 8'(cur_cfg[CFG_MIN_SPEED_PCT] + $urandom_range(0, 2) - 1);
            2: return 8'(cur_cfg[CFG_MAX_SPEED_PCT] + $urandom_range(0, 2) - 1);
            3: return 8'(cur_cfg[CFG_TURN_STOP_PCT] + $urandom_range(0, 2) - 1);
            4: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic drive_request_t random_request();
        drive_request_t rq;
        int side;
        side = cur_cfg[CFG_SIDE_DIFF_LIMIT];
        rq.auto_mode  = ($urandom_range(0, 99) < 35);
        rq.go         = ($urandom_range(0, 9) != 0);
        rq.ahead      = 1'($urandom_range(0, 1));
        rq.steer      = 2'($urandom_range(0, 3));
        rq.speed_pct  = pick_speed();
        rq.front_dist = pick_distance(cur_cfg[CFG_FRONT_STOP_DIST]);
        rq.back_dist  = pick_distance(cur_cfg[CFG_BACK_STOP_DIST]);
        case ($urandom_range(0, 4))
            0: rq.left_dist = 16'd0;
            1: rq.left_dist = 16'($urandom);
            default: rq.left_dist = 16'($urandom_range(1, 2000));
        endcase
        // right side near the steer threshold relative to the left
        case ($urandom_range(0, 6))
            0: rq.right_dist = 16'd0;
            1: rq.right_dist = 16'(rq.left_dist + side + $urandom_range(0, 2) - 1);
            2: rq.right_dist = 16'(rq.left_dist - side + $urandom_range(0, 2) - 1);
            3: rq.right_dist = rq.left_dist;
            4: rq.right_dist = 16'($urandom);
            default: rq.right_dist = 16'($urandom_range(1, 2000));
        endcase
        return rq;
    endfunction

    task automatic load_setting(input int md, input int mt, input int ms, input int mx,
                                input int ts, input int fs, input int bs, input int sd);
        cur_cfg[CFG_MIN_DUTY]        = md;
        cur_cfg[CFG_MIN_TURN_DUTY]   = mt;
        cur_cfg[CFG_MIN_SPEED_PCT]   = ms;
        cur_cfg[CFG_MAX_SPEED_PCT]   = mx;
        cur_cfg[CFG_TURN_STOP_PCT]   = ts;
        cur_cfg[CFG_FRONT_STOP_DIST] = fs;
        cur_cfg[CFG_BACK_STOP_DIST]  = bs;
        cur_cfg[CFG_SIDE_DIFF_LIMIT] = sd;
    endtask

    // offer one request and hold it until accepted
    task automatic send_request(input drive_request_t rq);
        while ($urandom_range(0, 99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.auto_mode;
        s_tdata  <= {4'b0, rq.right_dist, rq.left_dist, rq.back_dist, rq.front_dist,
                     rq.speed_pct, rq.steer, rq.ahead, rq.go};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        drive_request_t directed [$];
        int phase;
        int r;
        int n;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        long_hold = 1'b0;
        tx_idle   = 22;
        rx_idle   = 73;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed ticks under the reset register values
        directed.push_back(plan_request(0, 0, 1, TURN_NONE, 8'd50, 0, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_NONE, 8'd0, 0, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_NONE, 8'd255, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF));
        directed.push_back(plan_request(0, 1, 1, TURN_NONE, 8'd60, 16'd400, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_NONE, 8'd60, 16'd401, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_NONE, 8'd60, 16'd1, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 0, TURN_NONE, 8'd60, 0, 16'd400, 0, 0));
        directed.push_back(plan_request(0, 1, 0, TURN_NONE, 8'd60, 16'd1, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_LEFT, 8'd50, 0, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_RIGHT, 8'd50, 0, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_ODD, 8'd50, 0, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 1, TURN_LEFT, 8'd19, 0, 0, 0, 0));
        directed.push_back(plan_request(0, 1, 0, TURN_RIGHT, 8'd20, 0, 0, 0, 0));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 16'd200, 0, 0, 0));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 16'd200, 0, 16'd100, 0));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 16'd200, 0, 0, 16'd100));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 16'd200, 0, 16'd300,
                                        16'd300));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 16'd200, 0, 16'd500,
                                        16'd300));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 0, 0, 16'd380, 16'd300));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 0, 0, 16'd300, 16'd381));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 0, 0, 0, 16'd50));
        directed.push_back(plan_request(1, 0, 0, TURN_NONE, 8'd0, 0, 0, 16'd50, 0));
        directed.push_back(plan_request(1, 1, 1, TURN_LEFT, 8'd255, 0, 16'hFFFF, 0, 0));
        directed.push_back(plan_request(1, 1, 0, TURN_ODD, 8'd0, 16'hFFFF, 0, 16'hFFFF,
                                        16'd1));
        foreach (directed[i]) send_request(directed[i]);
        s_tvalid <= 1'b0;
        drain_results();

        // one phase per register setting
        for (phase = 0; phase < NUM_SETTINGS; phase++) begin
            if (phase < 3) begin
                tx_idle = 22;
                rx_idle = 73;
            end else if (phase < 6) begin
                tx_idle = 73;
                rx_idle = 22;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (phase)
                0: load_setting(10, 30, 10, 100, 25, 320, 320, 48);
                1: load_setting(0, 0, 0, 0, 0, 0, 0, 0);
                2: load_setting(255, 255, 99, 100, 100, 65535, 65535, 65535);
                // crossed clamps
                3: load_setting(40, 20, 60, 30, 50, 1000, 200, 10);
                // speed origin at 100 and above
                4: load_setting(20, 10, 100, 100, 0, 16, 16, 0);
                5: load_setting(255, 0, 127, 127, 127, 1, 1, 1);
                default: load_setting($urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 99), $urandom_range(0, 100),
                                      $urandom_range(0, 100), $urandom_range(0, 2000),
                                      $urandom_range(0, 2000), $urandom_range(0, 300));
            endcase

            // write every register, junk above the register width
            for (r = 0; r < 8; r++) begin
                cfg_valid <= 1'b1;
                cfg_index <= 3'(r);
                cfg_data  <= 16'(cur_cfg[r]) | (16'($urandom) & ~register_mask(3'(r)));
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
            end
            cfg_valid <= 1'b0;

            // fill the pipeline; in phase 6 this runs against a long stalled output
            if (phase == 6) long_hold = 1'b1;
            for (n = 0; n < PHASE_REQUESTS; n++) send_request(random_request());
            s_tvalid <= 1'b0;
            drain_results();
        end

        repeat (NSTG + 4) @(posedge aclk);
        $display("%0d requests over %0d register settings, %0d results compared",
                 requests_sent, NUM_SETTINGS + 1, compared);
        $display("manual and autonomous ticks, stop thresholds, clamp extremes, long stall");
        if (mismatches == 0) begin
            $display("[differential_drive_duty_planner_unit] OK");
        end else begin
            $display("[differential_drive_duty_planner_unit] ERROR");
        end
        $finish;
    end

endmodule
